FILE: rtl/mre_pkg.sv
// Package: opcodes, controller states and control structs for the R-type execute block
package mre_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 5;
  localparam int unsigned CntW  = 6;
  localparam logic [CntW-1:0] DivSteps = CntW'(WordW);

  typedef enum logic [4:0] {
    OP_NOR   = 5'd0,
    OP_AND   = 5'd1,
    OP_ADD   = 5'd2,
    OP_ADDU  = 5'd3,
    OP_SUB   = 5'd4,
    OP_SUBU  = 5'd5,
    OP_SLT   = 5'd6,
    OP_SLTU  = 5'd7,
    OP_DIV   = 5'd8,
    OP_DIVU  = 5'd9,
    OP_OR    = 5'd10,
    OP_MULT  = 5'd11,
    OP_MULTU = 5'd12,
    OP_XOR   = 5'd13,
    OP_SLLV  = 5'd14,
    OP_SRLV  = 5'd15,
    OP_MFHI  = 5'd16,
    OP_MFLO  = 5'd17,
    OP_MTHI  = 5'd18,
    OP_MTLO  = 5'd19,
    OP_SLL   = 5'd20,
    OP_SRAV  = 5'd21
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_MUL,
    ST_DIV,
    ST_DIVFIX,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands, compute combinational result
    logic mul_done;  // commit the registered product
    logic div_init;  // set up divider
    logic div_step;  // one restoring step
    logic div_fix;   // sign fix and commit quotient/remainder
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_zero;
  } dp_status_t;

endpackage

FILE: rtl/mre_ctrl.sv
// Controller FSM: sequences multiply, divide and the output handshake
module mre_ctrl import mre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // hold state and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      // route the captured transaction to multiply, divide or straight out
      ST_DISP: begin
        if (status.is_mul) begin
          state_nxt = ST_MUL;
        end else if (status.is_div && !status.div_zero) begin
          cmd.div_init = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_MUL: begin
        cmd.mul_done = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivSteps - 1'b1) state_nxt = ST_DIVFIX;
      end
      ST_DIVFIX: begin
        cmd.div_fix = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/mre_dp.sv
// Datapath: ALU, shifter, registered multiplier, restoring divider, HI/LO
module mre_dp import mre_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  input  logic [4:0]       in_opcode,
  input  logic [WordW-1:0] in_operand_a,
  input  logic [WordW-1:0] in_operand_b,
  input  logic [RegW-1:0]  in_dest_index,
  input  logic [RegW-1:0]  in_shift_amount,
  output logic             out_write_enable,
  output logic [RegW-1:0]  out_dest_out,
  output logic [WordW-1:0] out_write_value,
  output logic             out_overflow,
  output logic             out_divide_by_zero
);

  logic [WordW-1:0]   hi_r, hi_nxt, lo_r, lo_nxt;
  logic [4:0]         op_r;
  logic [WordW-1:0]   a_r, b_r;
  logic [2*WordW-1:0] prod_r;
  logic [WordW-1:0]   rem_r, quo_r;
  logic               we_r, ovf_r, dz_r;
  logic [RegW-1:0]    dest_r;
  logic [WordW-1:0]   val_r;

  logic [WordW-1:0] val_c, sum_c, diff_c;
  logic             we_c, ovf_c, dz_c;
  logic [WordW:0]   trial_c;
  logic [WordW-1:0] rem_sh_c;
  logic             a_neg, b_neg;
  logic [WordW-1:0] mag_a, mag_b;
  logic signed [WordW:0]     ma_s, mb_s;
  logic signed [2*WordW+1:0] prod_full;

  assign sum_c  = in_operand_a + in_operand_b;
  assign diff_c = in_operand_a - in_operand_b;

  // combinational result
  always_comb begin
    val_c = '0;
    we_c  = 1'b0;
    ovf_c = 1'b0;
    dz_c  = 1'b0;
    case (in_opcode)
      OP_NOR:  begin val_c = ~(in_operand_a | in_operand_b); we_c = 1'b1; end
      OP_AND:  begin val_c = in_operand_a & in_operand_b; we_c = 1'b1; end
      OP_OR:   begin val_c = in_operand_a | in_operand_b; we_c = 1'b1; end
      OP_XOR:  begin val_c = in_operand_a ^ in_operand_b; we_c = 1'b1; end
      OP_ADD: begin
        if (~(in_operand_a[31] ^ in_operand_b[31]) & (in_operand_a[31] ^ sum_c[31]))
          ovf_c = 1'b1;
        else begin
          val_c = sum_c; we_c = 1'b1;
        end
      end
      OP_ADDU: begin val_c = sum_c; we_c = 1'b1; end
      OP_SUB: begin
        if ((in_operand_a[31] ^ in_operand_b[31]) & (in_operand_a[31] ^ diff_c[31]))
          ovf_c = 1'b1;
        else begin
          val_c = diff_c; we_c = 1'b1;
        end
      end
      OP_SUBU: begin val_c = diff_c; we_c = 1'b1; end
      OP_SLT: begin
        val_c = {31'd0, $signed(in_operand_a) < $signed(in_operand_b)}; we_c = 1'b1;
      end
      OP_SLTU: begin val_c = {31'd0, in_operand_a < in_operand_b}; we_c = 1'b1; end
      OP_SLLV: begin val_c = in_operand_b << in_operand_a[4:0]; we_c = 1'b1; end
      OP_SRLV: begin val_c = in_operand_b >> in_operand_a[4:0]; we_c = 1'b1; end
      OP_SRAV: begin
        val_c = WordW'($signed(in_operand_b) >>> in_operand_a[4:0]); we_c = 1'b1;
      end
      OP_SLL:  begin val_c = in_operand_b << in_shift_amount; we_c = 1'b1; end
      OP_MFHI: begin val_c = hi_r; we_c = 1'b1; end
      OP_MFLO: begin val_c = lo_r; we_c = 1'b1; end
      OP_DIV, OP_DIVU: dz_c = (in_operand_b == '0);
      default: ;
    endcase
  end

  assign status.is_mul   = (op_r == OP_MULT) || (op_r == OP_MULTU);
  assign status.is_div   = (op_r == OP_DIV) || (op_r == OP_DIVU);
  assign status.div_zero = dz_r;

  // operand magnitudes for division
  assign a_neg = (op_r == OP_DIV) && a_r[31];
  assign b_neg = (op_r == OP_DIV) && b_r[31];
  assign mag_a = a_neg ? (~a_r + 1'b1) : a_r;
  assign mag_b = b_neg ? (~b_r + 1'b1) : b_r;

  // restoring step
  assign rem_sh_c = {rem_r[WordW-2:0], quo_r[WordW-1]};
  assign trial_c  = {rem_r[WordW-1], rem_sh_c} - {1'b0, mag_b};

  // sign-aware 33x33 product
  assign ma_s = (op_r == OP_MULT) ? $signed({a_r[31], a_r}) : $signed({1'b0, a_r});
  assign mb_s = (op_r == OP_MULT) ? $signed({b_r[31], b_r}) : $signed({1'b0, b_r});
  assign prod_full = ma_s * mb_s;

  // HI/LO updates
  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (cmd.load && in_opcode == OP_MTHI) hi_nxt = in_operand_a;
    if (cmd.load && in_opcode == OP_MTLO) lo_nxt = in_operand_a;
    if (cmd.mul_done) begin
      hi_nxt = prod_r[2*WordW-1:WordW];
      lo_nxt = prod_r[WordW-1:0];
    end
    if (cmd.div_fix) begin
      lo_nxt = (a_neg ^ b_neg) ? (~quo_r + 1'b1) : quo_r;
      hi_nxt = a_neg ? (~rem_r + 1'b1) : rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  // capture transaction, run multiplier and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      dest_r <= in_dest_index;
      val_r  <= val_c;
      we_r   <= we_c;
      ovf_r  <= ovf_c;
      dz_r   <= dz_c;
    end
    prod_r <= prod_full[2*WordW-1:0];
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= mag_a;
    end else if (cmd.div_step) begin
      if (!trial_c[WordW]) begin
        rem_r <= trial_c[WordW-1:0];
        quo_r <= {quo_r[WordW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh_c;
        quo_r <= {quo_r[WordW-2:0], 1'b0};
      end
    end
  end

  assign out_write_enable   = we_r;
  assign out_dest_out       = dest_r;
  assign out_write_value    = val_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dz_r;

endmodule

FILE: rtl/mips_r_type_execute_top.sv
// Channel   | Ports                                         | Direction
// input     | in_valid, in_stall, in_opcode.. shift_amount  | in
// result    | out_valid, out_stall, out_write_enable..      | out
// Logic, add, shift and move operations: the result is valid in the output state, reached
// through dispatch, then back to idle; MULT/MULTU add the HI/LO commit state before output.
// DIV/DIVU: 32 restoring steps plus sign fix before the result, run by the
// one-bit-per-cycle divider loop; a zero divisor skips the loop and goes straight to output.
// Reset (rst_n low, synchronous) clears the controller and HI/LO to zero.
// out_stall holds the result register; no input is taken until it is delivered.
module mips_r_type_execute_top import mre_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [4:0]       in_opcode,
  input  logic [WordW-1:0] in_operand_a,
  input  logic [WordW-1:0] in_operand_b,
  input  logic [RegW-1:0]  in_dest_index,
  input  logic [RegW-1:0]  in_shift_amount,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_write_enable,
  output logic [RegW-1:0]  out_dest_out,
  output logic [WordW-1:0] out_write_value,
  output logic             out_overflow,
  output logic             out_divide_by_zero
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mre_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd
  );

  mre_dp u_dp (
    .clk, .rst_n, .cmd, .status,
    .in_opcode, .in_operand_a, .in_operand_b, .in_dest_index, .in_shift_amount,
    .out_write_enable, .out_dest_out, .out_write_value, .out_overflow,
    .out_divide_by_zero
  );

endmodule

FILE: rtl/mre_checker.sv
// Port-level checker for the R-type execute block, bound to the top level
module mre_checker import mre_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_write_enable,
  input logic [WordW-1:0] out_write_value,
  input logic             out_overflow,
  input logic             out_divide_by_zero
);

  // never accept while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // no result without write shows a value
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_write_value == '0))
    else $error("nonzero value without write");

  // flags exclude a write
  a_flag_we: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_overflow || out_divide_by_zero)) |-> !out_write_enable)
    else $error("flag with write");

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

  // stalled input transaction stays
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid) else $error("input withdrawn while stalled");

endmodule

bind mips_r_type_execute_top mre_checker u_mre_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_write_enable, .out_write_value, .out_overflow, .out_divide_by_zero
);

FILE: sim/tb_mips_r_type_execute_top.sv
// Testbench for the R-type execute block: directed table, then random traffic with HI/LO tracking
`timescale 1ns / 100ps

module tb_mips_r_type_execute_top;
  import mre_pkg::*;

  typedef struct packed {
    logic [4:0]       op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [RegW-1:0]  rd;
    logic [RegW-1:0]  sa;
  } exec_req_t;

  typedef struct packed {
    logic             we;
    logic [RegW-1:0]  rd;
    logic [WordW-1:0] val;
    logic             ovf;
    logic             dz;
  } exec_res_t;

  typedef struct packed {
    exec_req_t req;
    logic      fixed;   // expected result typed in
    exec_res_t res;
  } table_row_t;

  localparam int NumRandom = 500;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] in_opcode = '0;
  logic [WordW-1:0] in_operand_a = '0;
  logic [WordW-1:0] in_operand_b = '0;
  logic [RegW-1:0] in_dest_index = '0;
  logic [RegW-1:0] in_shift_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_write_enable;
  logic [RegW-1:0] out_dest_out;
  logic [WordW-1:0] out_write_value;
  logic out_overflow;
  logic out_divide_by_zero;

  logic [WordW-1:0] model_hi = '0;
  logic [WordW-1:0] model_lo = '0;
  exec_res_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 83;

  mips_r_type_execute_top uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Compute the result of one operation and advance the HI/LO copy
  function automatic exec_res_t execute_op(exec_req_t q);
    exec_res_t r;
    logic [WordW-1:0] sum;
    logic [WordW-1:0] ma, mb, quo, rem;
    logic [63:0] prod;
    r = '0;
    r.rd = q.rd;
    case (q.op)
      OP_NOR:  begin r.val = ~(q.a | q.b); r.we = 1'b1; end
      OP_AND:  begin r.val = q.a & q.b; r.we = 1'b1; end
      OP_OR:   begin r.val = q.a | q.b; r.we = 1'b1; end
      OP_XOR:  begin r.val = q.a ^ q.b; r.we = 1'b1; end
      OP_ADD: begin
        sum = q.a + q.b;
        if (~(q.a[31] ^ q.b[31]) & (q.a[31] ^ sum[31])) r.ovf = 1'b1;
        else begin r.val = sum; r.we = 1'b1; end
      end
      OP_ADDU: begin r.val = q.a + q.b; r.we = 1'b1; end
      OP_SUB: begin
        sum = q.a - q.b;
        if ((q.a[31] ^ q.b[31]) & (q.a[31] ^ sum[31])) r.ovf = 1'b1;
        else begin r.val = sum; r.we = 1'b1; end
      end
      OP_SUBU: begin r.val = q.a - q.b; r.we = 1'b1; end
      OP_SLT: begin
        r.val = ($signed(q.a) < $signed(q.b)) ? 32'd1 : 32'd0; r.we = 1'b1;
      end
      OP_SLTU: begin r.val = (q.a < q.b) ? 32'd1 : 32'd0; r.we = 1'b1; end
      OP_DIV: begin
        if (q.b == 0) r.dz = 1'b1;
        else begin
          ma = q.a[31] ? -q.a : q.a;
          mb = q.b[31] ? -q.b : q.b;
          quo = ma / mb;
          rem = ma % mb;
          if (q.a[31] ^ q.b[31]) quo = -quo;
          if (q.a[31]) rem = -rem;
          model_lo = quo;
          model_hi = rem;
        end
      end
      OP_DIVU: begin
        if (q.b == 0) r.dz = 1'b1;
        else begin model_lo = q.a / q.b; model_hi = q.a % q.b; end
      end
      OP_MULT: begin
        prod = $signed({{32{q.a[31]}}, q.a}) * $signed({{32{q.b[31]}}, q.b});
        {model_hi, model_lo} = prod;
      end
      OP_MULTU: begin
        prod = {32'b0, q.a} * {32'b0, q.b};
        {model_hi, model_lo} = prod;
      end
      OP_SLLV: begin r.val = q.b << q.a[4:0]; r.we = 1'b1; end
      OP_SRLV: begin r.val = q.b >> q.a[4:0]; r.we = 1'b1; end
      OP_SRAV: begin r.val = $signed(q.b) >>> q.a[4:0]; r.we = 1'b1; end
      OP_SLL:  begin r.val = q.b << q.sa; r.we = 1'b1; end
      OP_MFHI: begin r.val = model_hi; r.we = 1'b1; end
      OP_MFLO: begin r.val = model_lo; r.we = 1'b1; end
      OP_MTHI: model_hi = q.a;
      OP_MTLO: model_lo = q.a;
      default: ;
    endcase
    return r;
  endfunction

  function automatic exec_req_t mk(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                   logic [4:0] rd, logic [4:0] sa);
    exec_req_t q;
    q.op = op; q.a = a; q.b = b; q.rd = rd; q.sa = sa;
    return q;
  endfunction

  function automatic exec_res_t mkres(logic we, logic [4:0] rd, logic [31:0] v,
                                      logic ovf, logic dz);
    exec_res_t r;
    r.we = we; r.rd = rd; r.val = v; r.ovf = ovf; r.dz = dz;
    return r;
  endfunction

  // Draw an operand biased toward corner values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // Drive one transaction and wait for its acceptance; valid stays up for the caller to drop
  task automatic send_item(exec_req_t q, logic fixed, exec_res_t res);
    exec_res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= q.op;
    in_operand_a <= q.a;
    in_operand_b <= q.b;
    in_dest_index <= q.rd;
    in_shift_amount <= q.sa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = execute_op(q);
    pending_results.push_back(fixed ? res : predicted);
    @(negedge clk);
  endtask

  // Random receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    exec_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = mkres(out_write_enable, out_dest_out, out_write_value, out_overflow,
                  out_divide_by_zero);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp we=%b rd=%0d val=%h ovf=%b dz=%b, ",
                     want.we, want.rd, want.val, want.ovf, want.dz,
                     "got we=%b rd=%0d val=%h ovf=%b dz=%b",
                     got.we, got.rd, got.val, got.ovf, got.dz);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  table_row_t directed[] = '{
    '{mk(OP_MFHI, 32'h0, 32'h0, 5'd1, 5'd0), 1'b1,
      mkres(1'b1, 5'd1, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_MFLO, 32'h0, 32'h0, 5'd31, 5'd0), 1'b1,
      mkres(1'b1, 5'd31, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_ADD, 32'h7FFFFFFF, 32'h1, 5'd2, 5'd0), 1'b1,
      mkres(1'b0, 5'd2, 32'h0, 1'b1, 1'b0)},
    '{mk(OP_SUB, 32'h80000000, 32'h1, 5'd3, 5'd0), 1'b1,
      mkres(1'b0, 5'd3, 32'h0, 1'b1, 1'b0)},
    '{mk(OP_ADDU, 32'hFFFFFFFF, 32'h1, 5'd4, 5'd0), 1'b1,
      mkres(1'b1, 5'd4, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_SUBU, 32'h0, 32'h1, 5'd5, 5'd0), 1'b1,
      mkres(1'b1, 5'd5, 32'hFFFFFFFF, 1'b0, 1'b0)},
    '{mk(OP_NOR, 32'h0, 32'h0, 5'd6, 5'd0), 1'b1,
      mkres(1'b1, 5'd6, 32'hFFFFFFFF, 1'b0, 1'b0)},
    '{mk(OP_AND, 32'hF0F0F0F0, 32'hFFFF0000, 5'd7, 5'd0), 1'b0, '0},
    '{mk(OP_OR, 32'h12345678, 32'h87654321, 5'd8, 5'd0), 1'b0, '0},
    '{mk(OP_XOR, 32'hFFFFFFFF, 32'hAAAAAAAA, 5'd9, 5'd0), 1'b0, '0},
    '{mk(OP_SLT, 32'h80000000, 32'h7FFFFFFF, 5'd10, 5'd0), 1'b1,
      mkres(1'b1, 5'd10, 32'h1, 1'b0, 1'b0)},
    '{mk(OP_SLTU, 32'h80000000, 32'h7FFFFFFF, 5'd11, 5'd0), 1'b1,
      mkres(1'b1, 5'd11, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_SLLV, 32'hFFFFFFE1, 32'h1, 5'd12, 5'd0), 1'b1,
      mkres(1'b1, 5'd12, 32'h2, 1'b0, 1'b0)},
    '{mk(OP_SRLV, 32'h3F, 32'h80000000, 5'd13, 5'd0), 1'b1,
      mkres(1'b1, 5'd13, 32'h1, 1'b0, 1'b0)},
    '{mk(OP_SRAV, 32'h1F, 32'h80000000, 5'd14, 5'd0), 1'b1,
      mkres(1'b1, 5'd14, 32'hFFFFFFFF, 1'b0, 1'b0)},
    '{mk(OP_SLL, 32'h0, 32'h1, 5'd15, 5'd31), 1'b1,
      mkres(1'b1, 5'd15, 32'h80000000, 1'b0, 1'b0)},
    '{mk(OP_MULT, 32'hFFFFFFFF, 32'h7FFFFFFF, 5'd16, 5'd0), 1'b1,
      mkres(1'b0, 5'd16, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_MFHI, 32'h0, 32'h0, 5'd17, 5'd0), 1'b0, '0},
    '{mk(OP_MULTU, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd18, 5'd0), 1'b0, '0},
    '{mk(OP_MFLO, 32'h0, 32'h0, 5'd19, 5'd0), 1'b0, '0},
    '{mk(OP_DIV, 32'h80000000, 32'hFFFFFFFF, 5'd20, 5'd0), 1'b1,
      mkres(1'b0, 5'd20, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_MFLO, 32'h0, 32'h0, 5'd21, 5'd0), 1'b1,
      mkres(1'b1, 5'd21, 32'h80000000, 1'b0, 1'b0)},
    '{mk(OP_DIVU, 32'h5, 32'h0, 5'd22, 5'd0), 1'b1,
      mkres(1'b0, 5'd22, 32'h0, 1'b0, 1'b1)},
    '{mk(OP_DIV, 32'hFFFFFFF9, 32'h2, 5'd23, 5'd0), 1'b0, '0},
    '{mk(OP_MTHI, 32'hDEADBEEF, 32'h0, 5'd24, 5'd0), 1'b1,
      mkres(1'b0, 5'd24, 32'h0, 1'b0, 1'b0)},
    '{mk(OP_MFHI, 32'h0, 32'h0, 5'd25, 5'd0), 1'b1,
      mkres(1'b1, 5'd25, 32'hDEADBEEF, 1'b0, 1'b0)},
    '{mk(5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd26, 5'd31), 1'b1,
      mkres(1'b0, 5'd26, 32'h0, 1'b0, 1'b0)}
  };

  initial begin
    exec_req_t q;
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed[i]) send_item(directed[i].req, directed[i].fixed, directed[i].res);

    // Hold off until every result has drained
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    for (n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin send_idle_pct = 83; recv_idle_pct = 31; end
      if (n == 2 * NumRandom / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
      q.op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(22, 31))
                                          : 5'($urandom_range(0, 21));
      q.a = pick_word();
      q.b = pick_word();
      q.rd = 5'($urandom);
      q.sa = 5'($urandom);
      send_item(q, 1'b0, '0);
    end

    // Drain, then let the bench idle before the verdict
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mre_pkg.sv
rtl/mre_ctrl.sv
rtl/mre_dp.sv
rtl/mips_r_type_execute_top.sv
rtl/mre_checker.sv
sim/tb_mips_r_type_execute_top.sv
